/* rtl/btw_pkg.sv */
`default_nettype none

package btw_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int WEIGHT_W    = 64;
    localparam int EXP_W       = 6;

    localparam logic [WEIGHT_W-1:0] VALUE_MASK = {WEIGHT_W{1'b1}} >> (WEIGHT_W - VALUE_WIDTH);

    // inverse of 3 mod 2^64, split in halves, and its multiples for the remainder fix
    localparam logic [31:0] INV3_LO  = 32'hAAAA_AAAB;
    localparam logic [31:0] INV3_HI  = 32'hAAAA_AAAA;
    localparam logic [63:0] INV3_X1  = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam logic [63:0] INV3_X2  = 64'h5555_5555_5555_5556;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CARRY
    } btw_state_t;

    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 3'd3)
            s = s - 3'd3;
        return s[1:0];
    endfunction

    // 64-bit value mod 3: base-4 digits summed mod 3 in a five-level tree
    function automatic logic [1:0] mod3_64(input logic [63:0] v);
        logic [1:0] acc [32];
        for (int i = 0; i < 32; i++) begin
            acc[i] = (v[2*i +: 2] == 2'd3) ? 2'd0 : v[2*i +: 2];
        end
        for (int lv = 0; lv < 5; lv++) begin
            for (int i = 0; i < 16; i++) begin
                if (i < (16 >> lv))
                    acc[i] = add_mod3(acc[2*i], acc[2*i+1]);
            end
        end
        return acc[0];
    endfunction

endpackage

`default_nettype wire

/* rtl/balanced_ternary_weights_core.sv */
// Each ternary digit goes through the shared divide-by-3 unit
// (multiply stage, then correction stage); the word for a nonzero digit k is
// registered onto the ports after its correction stage, a final carry word last.
// Words per input: one per nonzero digit of D base-3 digits (D <= 41 at 64 bits),
// plus at most one final carry word; a zero weight gives none. A new weight is taken only when idle.
// Words on strobe for one cycle, no stall; rst_n (async) idles and drops strobe.
`default_nettype none

module balanced_ternary_weights_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [btw_pkg::WEIGHT_W-1:0]  weight,
    output logic                               strobe,
    output logic                               side,
    output logic      [btw_pkg::EXP_W-1:0]     exponent,
    output logic                               last
);
    import btw_pkg::*;

    btw_state_t state_reg, state_next;

    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                carry_reg, carry_next;
    logic [EXP_W-1:0]    expo_reg, expo_next;

    logic                strobe_reg, strobe_next;
    logic                side_reg, side_next;
    logic [EXP_W-1:0]    exponent_reg, exponent_next;
    logic                last_reg, last_next;

    logic [WEIGHT_W-1:0] masked;
    logic [WEIGHT_W-1:0] quot;
    logic [1:0]          rem;
    logic [2:0]          digit;
    logic                accept;

    btw_div3 u_div3 (
        .clk   (clk),
        .value (w_reg),
        .quot  (quot),
        .rem   (rem)
    );

    assign masked = weight & VALUE_MASK;
    assign accept = start && (state_reg == ST_IDLE);
    assign digit  = {1'b0, rem} + {2'd0, carry_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (masked != '0))
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (quot != '0)
                    state_next = ST_MUL;
                else if (digit >= 3'd2)
                    state_next = ST_CARRY;
                else
                    state_next = ST_IDLE;
            end
            ST_CARRY:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        w_next     = w_reg;
        carry_next = carry_reg;
        expo_next  = expo_reg;
        case (state_reg)
            ST_IDLE:
            begin
                w_next     = masked;
                carry_next = 1'b0;
                expo_next  = '0;
            end
            ST_ACC:
            begin
                w_next     = quot;
                carry_next = (digit >= 3'd2);
                expo_next  = expo_reg + EXP_W'(1);
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_comb
    begin
        strobe_next   = 1'b0;
        side_next     = 1'b0;
        exponent_next = expo_reg;
        last_next     = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                strobe_next = (digit == 3'd1) || (digit == 3'd2);
                side_next   = (digit == 3'd2);
                last_next   = (digit == 3'd1) && (quot == '0);
            end
            ST_CARRY:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        carry_reg    <= carry_next;
        expo_reg     <= expo_next;
        side_reg     <= side_next;
        exponent_reg <= exponent_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign side     = side_reg;
    assign exponent = exponent_reg;
    assign last     = last_reg;

    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("word without work in progress");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (exponent <= 6'd41))
        else $error("exponent out of range");

    a_nonzero_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (masked != '0)) |=> busy)
        else $error("nonzero weight not taken");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("word right after last");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("idle before last word");

endmodule

`default_nettype wire

/* rtl/btw_div3.sv */
`default_nettype none

module btw_div3 (
    input  wire logic                          clk,
    input  wire logic [btw_pkg::WEIGHT_W-1:0]  value,
    output logic      [btw_pkg::WEIGHT_W-1:0]  quot,
    output logic      [1:0]                    rem
);
    import btw_pkg::*;

    logic [63:0] pp0_reg;
    logic [31:0] pp1_reg;
    logic [31:0] pp2_reg;
    logic [1:0]  rem_reg;
    logic [63:0] pp0_next;
    logic [31:0] pp1_next;
    logic [31:0] pp2_next;
    logic [31:0] mid_sum;
    logic [63:0] fix;

    // partial products of value * inv3 mod 2^64
    always_comb
    begin
        pp0_next = {32'd0, value[31:0]} * {32'd0, INV3_LO};
        pp1_next = value[63:32] * INV3_LO;
        pp2_next = value[31:0] * INV3_HI;
    end

    always_ff @(posedge clk)
    begin
        pp0_reg <= pp0_next;
        pp1_reg <= pp1_next;
        pp2_reg <= pp2_next;
        rem_reg <= mod3_64(value);
    end

    // (value - rem) * inv3 = exact quotient
    always_comb
    begin
        case (rem_reg)
            2'd1:    fix = INV3_X1;
            2'd2:    fix = INV3_X2;
            default: fix = 64'd0;
        endcase
        mid_sum = pp1_reg + pp2_reg;
        quot    = pp0_reg + {mid_sum, 32'd0} - fix;
        rem     = rem_reg;
    end

endmodule

`default_nettype wire
